/* design/gsf_pkg.sv */
// ----------------------------------------------------------------------------
// Gradient sharpen filter package
// Shared types, register indexes and field widths for the filter block.
// ----------------------------------------------------------------------------
package gsf_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_KERNEL = 2'd0;
    localparam logic [1:0] CFG_COLOR  = 2'd1;
    localparam logic [1:0] CFG_WIDTH  = 2'd2;
    localparam logic [1:0] CFG_HEIGHT = 2'd3;

    localparam int CFG_DATA_W = 16;
    localparam int COL_W      = 13;
    localparam int ROW_W      = 16;
    localparam int PIX_W      = 8;
    localparam int LINE_PAIR_W = 2 * PIX_W;

    // Kernel choice
    typedef enum logic [1:0] {
        K_ROBERTS   = 2'd0,
        K_PREWITT   = 2'd1,
        K_SOBEL     = 2'd2,
        K_LAPLACIAN = 2'd3
    } t_kernel;

    // Input transfer payload
    typedef struct packed {
        logic             func;
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_in_item;

    // Output transfer payload
    typedef struct packed {
        logic [PIX_W-1:0] sharpened;
        logic             frame_last;
    } t_out_item;

    // Border and frame flags of the output position
    typedef struct packed {
        logic col_first;
        logic col_last;
        logic row_first;
        logic row_last;
        logic frame_last;
    } t_tap_ctrl;

endpackage

/* design/gsf_line_mem.sv */
// ----------------------------------------------------------------------------
// Line memory
// Two gray lines packed per column address; one registered read port and
// one write port.
// ----------------------------------------------------------------------------
module gsf_line_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rd_en,
    input  logic [AW-1:0]                     i_rd_addr,
    output logic [gsf_pkg::LINE_PAIR_W-1:0]   o_rd_data,
    input  logic                              i_wr_en,
    input  logic [AW-1:0]                     i_wr_addr,
    input  logic [gsf_pkg::LINE_PAIR_W-1:0]   i_wr_data
);

    logic [gsf_pkg::LINE_PAIR_W-1:0] r_mem [DEPTH];
    logic [gsf_pkg::LINE_PAIR_W-1:0] r_rd_data;

    // Write the rotated column pair
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read on request, hold otherwise
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/gsf_kernel.sv */
// ----------------------------------------------------------------------------
// Gradient kernel
// Picks the reflected 3x3 taps, forms the kernel response, then the
// rounded magnitude and the saturated sharpened pixel.
// ----------------------------------------------------------------------------
module gsf_kernel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  gsf_pkg::t_tap_ctrl             i_ctrl,
    input  gsf_pkg::t_kernel               i_kernel,
    input  logic [8:0][gsf_pkg::PIX_W-1:0] i_win,
    output logic                           o_valid,
    output gsf_pkg::t_out_item             o_item
);

    logic [1:0]          col_sel [3];
    logic [1:0]          row_sel [3];
    logic signed [12:0]  pv [3][3];
    logic signed [12:0]  gx;
    logic signed [12:0]  gy;
    logic signed [12:0]  side_l;
    logic signed [12:0]  side_r;
    logic signed [12:0]  side_t;
    logic signed [12:0]  side_b;
    logic signed [12:0]  n_sum;
    logic [3:0]          tap_idx [3][3];

    logic                r_valid;
    logic signed [12:0]  r_sum;
    logic [gsf_pkg::PIX_W-1:0] r_center;
    logic                r_lap;
    logic                r_last;

    logic [11:0]         mag_abs;
    logic [11:0]         mag_q;
    logic [gsf_pkg::PIX_W-1:0] mag_sat;
    logic [gsf_pkg::PIX_W:0]   total;

    // Reflect-101 tap selection
    always_comb begin
        col_sel[0] = i_ctrl.col_first ? 2'd2 : 2'd0;
        col_sel[1] = 2'd1;
        col_sel[2] = i_ctrl.col_last ? col_sel[0] : 2'd2;
        row_sel[0] = i_ctrl.row_first ? 2'd2 : 2'd0;
        row_sel[1] = 2'd1;
        row_sel[2] = i_ctrl.row_last ? row_sel[0] : 2'd2;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                tap_idx[i][j] = 4'(row_sel[i]) * 4'd3 + 4'(col_sel[j]);
                pv[i][j] = $signed({5'd0, i_win[tap_idx[i][j]]});
            end
        end
    end

    // Kernel response
    always_comb begin
        side_l = pv[0][0] + pv[2][0];
        side_r = pv[0][2] + pv[2][2];
        side_t = pv[0][0] + pv[0][2];
        side_b = pv[2][0] + pv[2][2];
        gx     = '0;
        gy     = '0;
        n_sum  = '0;
        case (i_kernel)
            gsf_pkg::K_ROBERTS: begin
                gx    = pv[0][0] - pv[1][1];
                gy    = pv[0][1] - pv[1][0];
                n_sum = gx + gy;
            end
            gsf_pkg::K_PREWITT: begin
                gx    = (side_r + pv[1][2]) - (side_l + pv[1][0]);
                gy    = (side_t + pv[0][1]) - (side_b + pv[2][1]);
                n_sum = gx + gy;
            end
            gsf_pkg::K_SOBEL: begin
                gx    = (side_r + (pv[1][2] <<< 1)) - (side_l + (pv[1][0] <<< 1));
                gy    = (side_t + (pv[0][1] <<< 1)) - (side_b + (pv[2][1] <<< 1));
                n_sum = gx + gy;
            end
            gsf_pkg::K_LAPLACIAN: begin
                n_sum = (pv[1][1] <<< 2) - pv[0][1] - pv[2][1] - pv[1][0] - pv[1][2];
            end
            default: begin
                n_sum = '0;
            end
        endcase
    end

    // Stage register: valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    // Stage register: payload
    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_sum    <= n_sum;
            r_center <= i_win[4'd4 - 4'(i_ctrl.row_first && 1'b0)];
            r_lap    <= (i_kernel == gsf_pkg::K_LAPLACIAN);
            r_last   <= i_ctrl.frame_last;
        end
    end

    // Magnitude, half-to-even halving for pairs, saturate, sharpen
    always_comb begin
        mag_abs = r_sum[12] ? 12'(-r_sum) : 12'(r_sum);
        if (r_lap) begin
            mag_q = mag_abs;
        end else begin
            mag_q = (mag_abs >> 1) + 12'(mag_abs[0] & mag_abs[1]);
        end
        mag_sat = (mag_q > 12'd255) ? 8'd255 : mag_q[7:0];
        total   = {1'b0, mag_sat} + {1'b0, r_center};
        o_item.sharpened  = total[8] ? 8'd255 : total[7:0];
        o_item.frame_last = r_last;
    end

    assign o_valid = r_valid;

endmodule

/* design/gradient_sharpen_filter_unit.sv */
// ----------------------------------------------------------------------------
// Gradient sharpen filter unit
// Streams gray or BGR pixels through a two-line memory and a 3x3 window,
// adds the Roberts, Prewitt, Sobel or Laplacian magnitude to the gray pixel.
//
//   channel | direction | handshake                | payload
//   in      | input     | i_in_valid / o_in_ready  | i_in_data  (t_in_item)
//   out     | output    | o_out_valid / i_out_ready| o_out_data (t_out_item)
//   cfg     | input     | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// One item per cycle while the skid register is empty; the line memory does one
// read and one write-back per item, so its single read port sets the rate. A
// result passes the stage 0, window, kernel and output registers in turn.
// Synchronous active-low reset clears counters, window and valid flags; the
// line memory is not cleared and needs no clearing pass.
// A blocked output fills a skid register; o_in_ready drops on the next cycle
// and the whole pipe holds until the skid register empties.
// ----------------------------------------------------------------------------
module gradient_sharpen_filter_unit #(
    parameter int LINE_MAX = 4096
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  gsf_pkg::t_in_item                  i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output gsf_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int AW = (LINE_MAX > 2) ? $clog2(LINE_MAX) : 1;

    // Configuration
    gsf_pkg::t_kernel                r_kernel;
    logic                            r_color;
    logic [gsf_pkg::COL_W-1:0]       r_width;
    logic [gsf_pkg::ROW_W-1:0]       r_height;
    logic [gsf_pkg::COL_W-1:0]       n_width;
    logic [gsf_pkg::ROW_W-1:0]       n_height;
    logic [gsf_pkg::COL_W-1:0]       cfg_w_raw;

    // Positions
    logic [gsf_pkg::COL_W-1:0]       r_in_col;
    logic [gsf_pkg::ROW_W:0]         r_in_row;
    logic [gsf_pkg::COL_W-1:0]       r_out_col;
    logic [gsf_pkg::ROW_W-1:0]       r_out_row;
    logic [gsf_pkg::COL_W-1:0]       in_col_inc;
    logic [gsf_pkg::COL_W-1:0]       out_col_inc;
    logic                            restart;

    // Handshake and stage control
    logic                            adv;
    logic                            accept;
    logic                            pixels_done;
    logic                            enter;
    logic                            emit;
    gsf_pkg::t_tap_ctrl              tap_ctrl;

    // Stage 0: memory read issued
    logic                            r_s0_valid;
    logic                            r_s0_zero;
    logic                            r_s0_emit;
    logic [gsf_pkg::PIX_W-1:0]       r_s0_b;
    logic [gsf_pkg::PIX_W-1:0]       r_s0_g;
    logic [gsf_pkg::PIX_W-1:0]       r_s0_r;
    logic [AW-1:0]                   r_s0_addr;
    gsf_pkg::t_tap_ctrl              r_s0_ctrl;
    logic [gsf_pkg::LINE_PAIR_W-1:0] rd_data;
    logic [21:0]                     gray_sum;
    logic [gsf_pkg::PIX_W-1:0]       gray;
    logic                            wr_en;

    // Stage 1: window
    logic [8:0][gsf_pkg::PIX_W-1:0]  r_win;
    logic [8:0][gsf_pkg::PIX_W-1:0]  n_win;
    logic                            r_s1_valid;
    gsf_pkg::t_tap_ctrl              r_s1_ctrl;

    // Kernel result and output buffer
    logic                            k_valid;
    gsf_pkg::t_out_item              k_item;
    logic                            r_out_valid;
    gsf_pkg::t_out_item              r_out_data;
    logic                            r_skid_valid;
    gsf_pkg::t_out_item              r_skid_data;

    // Clamp size writes
    always_comb begin
        cfg_w_raw = i_cfg_data[gsf_pkg::COL_W-1:0];
        if (cfg_w_raw < 13'd2) begin
            n_width = 13'd2;
        end else if (32'(cfg_w_raw) > LINE_MAX) begin
            n_width = gsf_pkg::COL_W'(LINE_MAX);
        end else begin
            n_width = cfg_w_raw;
        end
        n_height = (i_cfg_data < 16'd2) ? 16'd2 : i_cfg_data;
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel <= gsf_pkg::K_ROBERTS;
            r_color  <= 1'b1;
            r_width  <= 13'd640;
            r_height <= 16'd480;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gsf_pkg::CFG_KERNEL: r_kernel <= gsf_pkg::t_kernel'(i_cfg_data[1:0]);
                gsf_pkg::CFG_COLOR:  r_color  <= i_cfg_data[0];
                gsf_pkg::CFG_WIDTH:  r_width  <= n_width;
                gsf_pkg::CFG_HEIGHT: r_height <= n_height;
                default: begin
                end
            endcase
        end
    end

    // Input side decisions
    assign adv         = !r_skid_valid;
    assign o_in_ready  = adv;
    assign accept      = i_in_valid && adv;
    assign pixels_done = r_in_row >= {1'b0, r_height};
    assign enter       = accept && !(i_in_data.func && !pixels_done);
    assign emit        = (r_in_row >= 17'd2) || ((r_in_row == 17'd1) && (r_in_col != '0));
    assign in_col_inc  = r_in_col + 13'd1;
    assign out_col_inc = r_out_col + 13'd1;
    assign restart     = i_cfg_we
                      && ((i_cfg_index == gsf_pkg::CFG_WIDTH)
                      ||  (i_cfg_index == gsf_pkg::CFG_HEIGHT));

    always_comb begin
        tap_ctrl.col_first  = (r_out_col == '0);
        tap_ctrl.col_last   = (r_out_col >= r_width - 13'd1);
        tap_ctrl.row_first  = (r_out_row == '0);
        tap_ctrl.row_last   = (r_out_row >= r_height - 16'd1);
        tap_ctrl.frame_last = tap_ctrl.col_last && tap_ctrl.row_last;
    end

    // Advance positions; restart on size write or after the frame's last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else if (enter) begin
            if (emit && tap_ctrl.frame_last) begin
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                if (in_col_inc >= r_width) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + 17'd1;
                end else begin
                    r_in_col <= in_col_inc;
                end
                if (emit) begin
                    if (out_col_inc >= r_width) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + 16'd1;
                    end else begin
                        r_out_col <= out_col_inc;
                    end
                end
            end
        end
    end

    // Stage 0 valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (adv) begin
            r_s0_valid <= enter;
        end
    end

    // Stage 0 payload
    always_ff @(posedge i_clk) begin
        if (enter) begin
            r_s0_zero <= pixels_done;
            r_s0_emit <= emit;
            r_s0_b    <= i_in_data.blue;
            r_s0_g    <= i_in_data.green;
            r_s0_r    <= i_in_data.red;
            r_s0_addr <= AW'(r_in_col);
            r_s0_ctrl <= tap_ctrl;
        end
    end

    // Line memory: read at transfer, write back the rotated pair from stage 0
    // on advance. Consecutive items in a frame differ in column: no forwarding.
    assign wr_en = adv && r_s0_valid;

    gsf_line_mem #(
        .DEPTH (LINE_MAX),
        .AW    (AW)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_rd_en   (enter),
        .i_rd_addr (AW'(r_in_col)),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s0_addr),
        .i_wr_data ({rd_data[gsf_pkg::PIX_W-1:0], gray})
    );

    // Gray conversion
    always_comb begin
        gray_sum = 22'(r_s0_b) * 22'd1868 + 22'(r_s0_g) * 22'd9617
                 + 22'(r_s0_r) * 22'd4899 + 22'd8192;
        if (r_s0_zero) begin
            gray = '0;
        end else if (r_color) begin
            gray = gray_sum[21:14];
        end else begin
            gray = r_s0_b;
        end
    end

    // Shift the window and load the new column
    always_comb begin
        n_win = r_win;
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]   = r_win[i*3+1];
            n_win[i*3+1] = r_win[i*3+2];
        end
        n_win[2] = rd_data[gsf_pkg::LINE_PAIR_W-1:gsf_pkg::PIX_W];
        n_win[5] = rd_data[gsf_pkg::PIX_W-1:0];
        n_win[8] = gray;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= '0;
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_s0_valid && r_s0_emit;
            if (r_s0_valid) begin
                r_win <= n_win;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s0_valid) begin
            r_s1_ctrl <= r_s0_ctrl;
        end
    end

    gsf_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_adv    (adv),
        .i_valid  (r_s1_valid),
        .i_ctrl   (r_s1_ctrl),
        .i_kernel (r_kernel),
        .i_win    (r_win),
        .o_valid  (k_valid),
        .o_item   (k_item)
    );

    // Output register and skid: control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_out_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (k_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register and skid: data
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (i_out_ready) begin
                r_out_data <= r_skid_data;
            end
        end else if (k_valid) begin
            if (r_out_valid && !i_out_ready) begin
                r_skid_data <= k_item;
            end else begin
                r_out_data <= k_item;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* design/gsf_checker.sv */
// ----------------------------------------------------------------------------
// Gradient sharpen filter checker
// Port-level checks on stall, reset and output holding behavior.
// ----------------------------------------------------------------------------
module gsf_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               o_in_ready,
    input  gsf_pkg::t_in_item                  i_in_data,
    input  logic                               o_out_valid,
    input  logic                               i_out_ready,
    input  gsf_pkg::t_out_item                 o_out_data,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_index,
    input  logic [gsf_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Reset empties the output and opens the input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("output valid or input stall after reset");

    // Input stalls only behind a waiting result
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // Input ready falls only after a refused output transfer
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_in_ready) |-> $past(o_out_valid && !i_out_ready))
        else $error("input ready fell without output back-pressure");

    // A refused result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output result dropped or changed while stalled");

endmodule

bind gradient_sharpen_filter_unit gsf_checker u_gsf_checker (.*);

/* tb/tb_gradient_sharpen_filter_unit.sv */
// ----------------------------------------------------------------------------
// Gradient sharpen filter unit testbench
// Streams gray and BGR frames of many sizes through the filter under all four
// kernels. A behavioral model of the window, borders and magnitude predicts
// every output pixel. Each output transfer is checked in order against the
// model or a directed row's pixel. Both channels idle at random, and the
// output side holds off once long enough to back-pressure the input.
// ----------------------------------------------------------------------------
module tb_gradient_sharpen_filter_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import gsf_pkg::*;

    localparam int LINE_MAX     = 4096;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SETTLE       = 12;
    localparam int RANDOM_ITEMS = 1250;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_LEN     = 400;
    localparam int NO_CAP       = 1 << 30;

    // Item kinds carried in the func field
    localparam logic FN_PIXEL = 1'b0;
    localparam logic FN_DRAIN = 1'b1;

    typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_HARSH} texture_e;
    typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_e;

    typedef struct packed {
        row_kind_e  kind;
        logic [1:0] idx;
        logic [15:0] val;
        t_in_item   item;
        logic       typed;
        t_out_item  want;
    } plan_row_t;

    localparam t_out_item NO_WANT     = '0;
    localparam t_out_item WHITE_MID   = '{8'd255, 1'b0};
    localparam t_out_item WHITE_LAST  = '{8'd255, 1'b1};
    localparam t_in_item  DRAIN_ITEM  = '{FN_DRAIN, 8'd0, 8'd0, 8'd0};
    localparam t_in_item  GRAY_WHITE  = '{FN_PIXEL, 8'd255, 8'd0, 8'd0};

    // Directed stimulus: reset state, smallest frames, every kernel, border cases
    localparam int PLAN_LEN = 35;
    localparam plan_row_t PLAN [PLAN_LEN] = '{
        // partial frame at reset size, then a size write restarts it
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd10, 8'd20, 8'd30}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd200, 8'd100, 8'd50}, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_WIDTH, 16'd0, '0, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_HEIGHT, 16'd1, '0, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_COLOR, 16'd0, '0, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_KERNEL, 16'(K_ROBERTS), '0, 1'b0, NO_WANT},
        // flat white 2x2 gray frame, early drain is dropped
        '{ROW_ITEM,  '0, '0, GRAY_WHITE, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, GRAY_WHITE, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, GRAY_WHITE, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, GRAY_WHITE, 1'b1, WHITE_MID},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b1, WHITE_MID},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b1, WHITE_MID},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b1, WHITE_LAST},
        // BGR extremes under the Laplacian, a pixel past the end acts as drain
        '{ROW_WRITE, CFG_COLOR, 16'd1, '0, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_KERNEL, 16'(K_LAPLACIAN), '0, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd0, 8'd0, 8'd0}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd255, 8'd255, 8'd255}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd255, 8'd0, 8'd0}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd0, 8'd255, 8'd0}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd0, 8'd0, 8'd255}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT},
        // 2x3 frame, Sobel switched to Prewitt mid-frame
        '{ROW_WRITE, CFG_HEIGHT, 16'd3, '0, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_KERNEL, 16'(K_SOBEL), '0, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd17, 8'd200, 8'd3}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd90, 8'd90, 8'd90}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd1, 8'd128, 8'd254}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd255, 8'd64, 8'd0}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd33, 8'd7, 8'd170}, 1'b0, NO_WANT},
        '{ROW_WRITE, CFG_KERNEL, 16'(K_PREWITT), '0, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, '{FN_PIXEL, 8'd128, 8'd128, 8'd128}, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT},
        '{ROW_ITEM,  '0, '0, DRAIN_ITEM, 1'b0, NO_WANT}
    };

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_item              i_in_data;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_item             o_out_data;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int cycle_cnt    = 0;
    int errors       = 0;
    int results_seen = 0;
    int items_sent   = 0;
    wire quiet = (cycle_cnt >= 2000) && (cycle_cnt < 5000);

    // Model state: settings, two gray lines, 3x3 neighborhood, positions
    t_kernel    k_mode;
    logic       bgr_on;
    int         cols_per_row;
    int         rows_per_frame;
    logic [7:0] gray_lines [2*LINE_MAX];
    logic [7:0] nbhd [9];
    int         wr_col, wr_row, rd_col, rd_row;
    t_out_item  awaited [$];
    t_out_item  head;

    gradient_sharpen_filter_unit #(
        .LINE_MAX (LINE_MAX)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Count cycles and stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic void restart_positions();
        wr_col = 0;
        wr_row = 0;
        rd_col = 0;
        rd_row = 0;
    endfunction

    function automatic void model_reset();
        k_mode         = K_ROBERTS;
        bgr_on         = 1'b1;
        cols_per_row   = 640;
        rows_per_frame = 480;
        foreach (gray_lines[n]) gray_lines[n] = '0;
        foreach (nbhd[n]) nbhd[n] = '0;
        restart_positions();
    endfunction

    // Apply a register write; size writes clamp and restart the frame
    function automatic void model_write(logic [1:0] idx, logic [15:0] val);
        int v;
        case (idx)
            CFG_KERNEL: k_mode = t_kernel'(val[1:0]);
            CFG_COLOR:  bgr_on = val[0];
            CFG_WIDTH: begin
                v = int'(val[12:0]);
                if (v < 2) v = 2;
                if (v > LINE_MAX) v = LINE_MAX;
                cols_per_row = v;
                restart_positions();
            end
            CFG_HEIGHT: begin
                v = int'(val);
                if (v < 2) v = 2;
                rows_per_frame = v;
                restart_positions();
            end
            default: ;
        endcase
    endfunction

    // Gradient magnitude of a row-major 3x3 tap set, saturated at 255
    function automatic int grad_mag(input int nb [9]);
        int gx, gy, w, s, a, q;
        if (k_mode == K_LAPLACIAN) begin
            s = 4 * nb[4] - nb[1] - nb[7] - nb[3] - nb[5];
            q = (s < 0) ? -s : s;
        end else begin
            if (k_mode == K_ROBERTS) begin
                gx = nb[0] - nb[4];
                gy = nb[1] - nb[3];
            end else begin
                w  = (k_mode == K_SOBEL) ? 2 : 1;
                gx = (nb[2] + w * nb[5] + nb[8]) - (nb[0] + w * nb[3] + nb[6]);
                gy = (nb[0] + w * nb[1] + nb[2]) - (nb[6] + w * nb[7] + nb[8]);
            end
            s = gx + gy;
            a = (s < 0) ? -s : s;
            q = a / 2;
            // halves round to the even neighbor
            if (a % 2 == 1) q = q + (q % 2);
        end
        return (q > 255) ? 255 : q;
    endfunction

    // Advance the model by one item; returns 1 when an output pixel is due
    function automatic bit sharpen_step(input t_in_item it, output bit taken,
                                        output t_out_item res);
        bit done, emit, last;
        int gray, x, v, i, j;
        int cix [3];
        int rix [3];
        int taps [9];
        done  = wr_row >= rows_per_frame;
        taken = 1'b1;
        res   = '0;
        // drop a drain while pixels are still expected
        if (it.func == FN_DRAIN && !done) begin
            taken = 1'b0;
            return 1'b0;
        end
        gray = 0;
        if (it.func == FN_PIXEL && !done)
            gray = bgr_on ? (1868 * int'(it.blue) + 9617 * int'(it.green)
                             + 4899 * int'(it.red) + 8192) >> 14
                          : int'(it.blue);
        x = wr_col % LINE_MAX;
        if (wr_col >= LINE_MAX) x = LINE_MAX - 1;
        for (i = 0; i < 3; i++) begin
            nbhd[i*3]   = nbhd[i*3+1];
            nbhd[i*3+1] = nbhd[i*3+2];
        end
        nbhd[2] = gray_lines[x];
        nbhd[5] = gray_lines[LINE_MAX+x];
        nbhd[8] = gray[7:0];
        gray_lines[x]          = gray_lines[LINE_MAX+x];
        gray_lines[LINE_MAX+x] = gray[7:0];

        emit = (wr_row >= 2) || (wr_row == 1 && wr_col >= 1);
        wr_col++;
        if (wr_col >= cols_per_row) begin
            wr_col = 0;
            wr_row++;
        end
        if (!emit) return 1'b0;

        // reflect-101 at the frame borders
        cix[0] = (rd_col == 0) ? 2 : 0;
        cix[1] = 1;
        cix[2] = (rd_col >= cols_per_row - 1) ? cix[0] : 2;
        rix[0] = (rd_row == 0) ? 2 : 0;
        rix[1] = 1;
        rix[2] = (rd_row >= rows_per_frame - 1) ? rix[0] : 2;
        for (i = 0; i < 3; i++)
            for (j = 0; j < 3; j++)
                taps[i*3+j] = int'(nbhd[rix[i]*3 + cix[j]]);

        last = (rd_row >= rows_per_frame - 1) && (rd_col >= cols_per_row - 1);
        v = taps[4] + grad_mag(taps);
        res.sharpened  = (v > 255) ? 8'd255 : v[7:0];
        res.frame_last = last;
        rd_col++;
        if (rd_col >= cols_per_row) begin
            rd_col = 0;
            rd_row++;
        end
        if (last) restart_positions();
        return 1'b1;
    endfunction

    function automatic logic [7:0] pick_level(texture_e tex, logic [7:0] near);
        int v;
        case (tex)
            TEX_NOISE:  v = $urandom_range(0, 255);
            TEX_SMOOTH: v = int'(near) + int'($urandom_range(0, 16)) - 8;
            default:    v = ($urandom_range(0, 3) != 0) ? 255 * $urandom_range(0, 1)
                                                        : $urandom_range(0, 255);
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Hold the input idle until every output pixel is in, plus the pipe latency
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (awaited.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        wait_idle();
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        model_write(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Offer one item, wait for its transfer, and queue the predicted pixel
    task automatic offer_item(input t_in_item it, input bit use_want, input t_out_item want,
                              output bit taken, output bit closed);
        bit        emitted;
        t_out_item res;
        @(negedge i_clk);
        if (!quiet && $urandom_range(0, 99) < 7) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (!o_in_ready);
        emitted = sharpen_step(it, taken, res);
        if (emitted) awaited.push_back(use_want ? want : res);
        closed = emitted && res.frame_last;
        if (taken) items_sent++;
    endtask

    // Stream one frame with random texture; stop early after cap items
    task automatic run_frame(int cap);
        int       sent;
        bit       taken, closed;
        t_in_item it;
        texture_e tex;
        sent   = 0;
        closed = 1'b0;
        it     = '0;
        tex    = texture_e'($urandom_range(0, 2));
        while (!closed && sent < cap) begin
            // now and then change kernel and color mid-frame
            if ($urandom_range(0, 99) < 2) begin
                write_reg(CFG_KERNEL, 16'($urandom_range(0, 65535)));
                write_reg(CFG_COLOR, 16'($urandom_range(0, 65535)));
            end
            if (wr_row < rows_per_frame)
                it.func = ($urandom_range(0, 99) < 4) ? FN_DRAIN : FN_PIXEL;
            else
                it.func = ($urandom_range(0, 99) < 10) ? FN_PIXEL : FN_DRAIN;
            it.blue  = pick_level(tex, it.blue);
            it.green = pick_level(tex, it.green);
            it.red   = pick_level(tex, it.red);
            offer_item(it, 1'b0, NO_WANT, taken, closed);
            sent++;
        end
    endtask

    // Output side: random stalls plus one long hold-off
    initial begin
        int  hold;
        bit  held;
        hold        = 0;
        held        = 1'b0;
        i_out_ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= HOLD_AT) begin
                held = 1'b1;
                hold = HOLD_LEN;
            end
            if (hold > 0) begin
                i_out_ready = 1'b0;
                hold--;
            end else begin
                i_out_ready = quiet || ($urandom_range(0, 99) >= 7);
            end
        end
    end

    // Check each output transfer against the oldest predicted pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected pixel, expected none, actual %0d last %0b",
                         $time, o_out_data.sharpened, o_out_data.frame_last);
                errors++;
            end else begin
                head = awaited.pop_front();
                if (o_out_data.sharpened !== head.sharpened) begin
                    $display("%0t: sharpened expected %0d actual %0d",
                             $time, head.sharpened, o_out_data.sharpened);
                    errors++;
                end
                if (o_out_data.frame_last !== head.frame_last) begin
                    $display("%0t: frame_last expected %0b actual %0b",
                             $time, head.frame_last, o_out_data.frame_last);
                    errors++;
                end
            end
        end
    end

    initial begin
        int w, h;
        bit taken, closed;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_KERNEL;
        i_cfg_data  = '0;
        model_reset();
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Walk the directed table
        for (int n = 0; n < PLAN_LEN; n++) begin
            if (PLAN[n].kind == ROW_WRITE)
                write_reg(PLAN[n].idx, PLAN[n].val);
            else
                offer_item(PLAN[n].item, PLAN[n].typed, PLAN[n].want, taken, closed);
        end

        // Widest frame: oversized width clamps to the line length
        write_reg(CFG_KERNEL, 16'($urandom_range(0, 3)));
        write_reg(CFG_COLOR, 16'($urandom_range(0, 1)));
        write_reg(CFG_WIDTH, 16'hFFFF);
        write_reg(CFG_HEIGHT, 16'd2);
        run_frame(NO_CAP);

        // Tallest frame: run the first rows, the next size write restarts it
        write_reg(CFG_WIDTH, 16'd3);
        write_reg(CFG_HEIGHT, 16'hFFFF);
        run_frame(90);

        // Random phases of small frames
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            write_reg(CFG_KERNEL, 16'($urandom_range(0, 65535)));
            write_reg(CFG_COLOR, 16'($urandom_range(0, 65535)));
            if ($urandom_range(0, 99) < 10)
                w = $urandom_range(0, 1);
            else if ($urandom_range(0, 99) < 20)
                w = $urandom_range(10, 40);
            else
                w = $urandom_range(2, 9);
            h = ($urandom_range(0, 99) < 10) ? $urandom_range(0, 1) : $urandom_range(2, 7);
            write_reg(CFG_WIDTH, 16'(w));
            write_reg(CFG_HEIGHT, 16'(h));
            repeat ($urandom_range(1, 3))
                run_frame(($urandom_range(0, 99) < 15)
                          ? $urandom_range(1, 3 * cols_per_row) : NO_CAP);
        end

        wait_idle();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
